FILE: hdl/mscd_pkg.sv
package mscd_pkg;

	localparam int SLOT_COUNT  = 32;
	localparam int COUNT_WIDTH = 16;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

	localparam int OP_W         = 2;
	localparam int STAT_W       = 3;
	localparam int SEC_W        = 16;
	localparam int CB_W         = 8;
	localparam int TAG_W        = 32;
	localparam int SLOT_FIELD_W = 5;

	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_ARG    = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 3'd3;
	localparam logic [STAT_W-1:0] ST_EXPIRED    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_FIND = 4'b0010,
		S_TICK = 4'b0100,
		S_LAST = 4'b1000
	} state_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
		logic [CB_W-1:0]        callback;
		logic [TAG_W-1:0]       tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] count;
		logic                   zero;
	} dec_res_t;

endpackage

FILE: hdl/mscd_ram.sv
module mscd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/mscd_dec.sv
module mscd_dec (
	input  logic [mscd_pkg::COUNT_WIDTH-1:0] count,
	output mscd_pkg::dec_res_t               res
);

	// count wraps at COUNT_WIDTH bits; active slots never hold zero
	assign res.count = count - mscd_pkg::COUNT_WIDTH'(1);
	assign res.zero  = (res.count == '0);

endmodule

FILE: hdl/multi_slot_countdown_timer_core.sv
// Table of countdown timer slots.
// Input: drive operation and its arguments with start high; the item is taken
// at a clock edge where start is high and busy is low. Create stores a count,
// a callback id and a tag in the lowest free slot; cancel frees a slot; tick
// decrements every active slot and reports each one that reaches zero.
// Output: every result is shown for exactly one cycle with valid high, and
// last marks the final result of an item. The receiver cannot stall it.
// Flow: bad arguments, cancels and unknown operations give
// their result in the cycle after the accept and leave busy low, so one such
// item can be taken every cycle. A create walks the active bits one slot per
// cycle and stays busy until it takes a free slot or finds the table full.
// A tick walks all slots through the single read port of the slot RAM, one
// slot per cycle, and stays busy until the walk ends; each expiry is held
// until the next one is found, and the final result comes with busy falling.
// Reset clears all active bits; slot contents are written on create.
module multi_slot_countdown_timer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  operation,
	input  logic [15:0] seconds,
	input  logic [7:0]  callback_id,
	input  logic [31:0] user_tag,
	input  logic [4:0]  slot,
	output logic        busy,
	output logic        valid,
	output logic [2:0]  status,
	output logic [4:0]  slot_index,
	output logic [7:0]  expired_callback,
	output logic [31:0] expired_tag,
	output logic        last
);

	localparam int SW = mscd_pkg::SLOT_W;
	localparam int CW = mscd_pkg::CNT_W;

	mscd_pkg::state_t state_q, state_d;
	logic [CW-1:0]    ptr_q, ptr_d;
	logic [mscd_pkg::SLOT_COUNT-1:0] active_q, active_d;
	logic             v_s1, v_s1_d;
	logic [SW-1:0]    idx_s1;
	mscd_pkg::entry_t new_q, new_d;

	logic                       pend_q, pend_d;
	logic [SW-1:0]              pend_idx_q, pend_idx_d;
	logic [mscd_pkg::CB_W-1:0]  pend_cb_q, pend_cb_d;
	logic [mscd_pkg::TAG_W-1:0] pend_tag_q, pend_tag_d;

	logic                           emit;
	logic [mscd_pkg::STAT_W-1:0]    e_status;
	logic [mscd_pkg::SLOT_FIELD_W-1:0] e_idx;
	logic [mscd_pkg::CB_W-1:0]      e_cb;
	logic [mscd_pkg::TAG_W-1:0]     e_tag;
	logic                           e_last;

	logic             we;
	logic [SW-1:0]    waddr;
	mscd_pkg::entry_t wdata;
	logic [SW-1:0]    raddr;
	mscd_pkg::entry_t rdata;
	mscd_pkg::dec_res_t dec;

	logic accept;
	logic bad_create;

	mscd_ram #(
		.WIDTH(mscd_pkg::ENTRY_W),
		.DEPTH(mscd_pkg::SLOT_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	mscd_dec u_dec (
		.count(rdata.count),
		.res  (dec)
	);

	assign busy   = (state_q != mscd_pkg::S_IDLE);
	assign accept = start && !busy;
	assign bad_create = (seconds == '0) || (callback_id == '0) ||
		((32'(seconds) >> mscd_pkg::COUNT_WIDTH) != 32'd0);

	always_comb begin
		state_d    = state_q;
		ptr_d      = ptr_q;
		active_d   = active_q;
		v_s1_d     = 1'b0;
		new_d      = new_q;
		pend_d     = pend_q;
		pend_idx_d = pend_idx_q;
		pend_cb_d  = pend_cb_q;
		pend_tag_d = pend_tag_q;
		emit       = 1'b0;
		e_status   = mscd_pkg::ST_OK;
		e_idx      = '0;
		e_cb       = '0;
		e_tag      = '0;
		e_last     = 1'b1;
		we         = 1'b0;
		waddr      = idx_s1;
		wdata      = '{count: dec.count, callback: rdata.callback, tag: rdata.tag};
		raddr      = ptr_q[SW-1:0];

		case (state_q)
			mscd_pkg::S_IDLE: begin
				if (accept) begin
					case (operation)
						mscd_pkg::OP_CREATE: begin
							if (bad_create) begin
								emit     = 1'b1;
								e_status = mscd_pkg::ST_BAD_ARG;
							end else begin
								new_d = '{count: mscd_pkg::COUNT_WIDTH'(seconds),
									callback: callback_id, tag: user_tag};
								ptr_d   = '0;
								state_d = mscd_pkg::S_FIND;
							end
						end
						mscd_pkg::OP_CANCEL: begin
							emit = 1'b1;
							if (32'(slot) >= mscd_pkg::SLOT_COUNT) begin
								e_status = mscd_pkg::ST_BAD_ARG;
							end else if (!active_q[SW'(slot)]) begin
								e_status = mscd_pkg::ST_NOT_ACTIVE;
							end else begin
								active_d[SW'(slot)] = 1'b0;
								e_idx = slot;
							end
						end
						mscd_pkg::OP_TICK: begin
							ptr_d   = '0;
							pend_d  = 1'b0;
							state_d = mscd_pkg::S_TICK;
						end
						default: begin
							emit     = 1'b1;
							e_status = mscd_pkg::ST_BAD_ARG;
						end
					endcase
				end
			end
			mscd_pkg::S_FIND: begin
				if (!active_q[ptr_q[SW-1:0]]) begin
					we    = 1'b1;
					waddr = ptr_q[SW-1:0];
					wdata = new_q;
					active_d[ptr_q[SW-1:0]] = 1'b1;
					emit  = 1'b1;
					e_idx = mscd_pkg::SLOT_FIELD_W'(ptr_q[SW-1:0]);
					state_d = mscd_pkg::S_IDLE;
				end else if (ptr_q == CW'(mscd_pkg::SLOT_COUNT - 1)) begin
					emit     = 1'b1;
					e_status = mscd_pkg::ST_FULL;
					state_d  = mscd_pkg::S_IDLE;
				end else begin
					ptr_d = ptr_q + CW'(1);
				end
			end
			mscd_pkg::S_TICK: begin
				// issue stage: read the next slot and note whether it is active
				if (ptr_q != CW'(mscd_pkg::SLOT_COUNT)) begin
					v_s1_d = active_q[ptr_q[SW-1:0]];
					ptr_d  = ptr_q + CW'(1);
				end else begin
					state_d = mscd_pkg::S_LAST;
				end
				// update stage: write back the decremented count
				if (v_s1) begin
					we = 1'b1;
					if (dec.zero) begin
						active_d[idx_s1] = 1'b0;
						// release the held expiry now that another follows
						if (pend_q) begin
							emit     = 1'b1;
							e_status = mscd_pkg::ST_EXPIRED;
							e_idx    = mscd_pkg::SLOT_FIELD_W'(pend_idx_q);
							e_cb     = pend_cb_q;
							e_tag    = pend_tag_q;
							e_last   = 1'b0;
						end
						pend_d     = 1'b1;
						pend_idx_d = idx_s1;
						pend_cb_d  = rdata.callback;
						pend_tag_d = rdata.tag;
					end
				end
			end
			mscd_pkg::S_LAST: begin
				emit = 1'b1;
				if (pend_q) begin
					e_status = mscd_pkg::ST_EXPIRED;
					e_idx    = mscd_pkg::SLOT_FIELD_W'(pend_idx_q);
					e_cb     = pend_cb_q;
					e_tag    = pend_tag_q;
				end
				state_d = mscd_pkg::S_IDLE;
			end
			default: begin
				state_d = mscd_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mscd_pkg::S_IDLE;
			ptr_q    <= '0;
			active_q <= '0;
			v_s1     <= 1'b0;
			pend_q   <= 1'b0;
			valid    <= 1'b0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			active_q <= active_d;
			v_s1     <= v_s1_d;
			pend_q   <= pend_d;
			valid    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1     <= ptr_q[SW-1:0];
		new_q      <= new_d;
		pend_idx_q <= pend_idx_d;
		pend_cb_q  <= pend_cb_d;
		pend_tag_q <= pend_tag_d;
		if (emit) begin
			status           <= e_status;
			slot_index       <= e_idx;
			expired_callback <= e_cb;
			expired_tag      <= e_tag;
			last             <= e_last;
		end
	end

	a_done_has_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> valid && last)
		else $error("item finished without a final result");

	a_mid_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final result while idle");

	a_tick_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && operation == mscd_pkg::OP_TICK |=> busy)
		else $error("tick accepted without walking the slots");

	a_s1_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> state_q == mscd_pkg::S_TICK)
		else $error("slot update outside a tick walk");

	a_pend_freed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mscd_pkg::S_LAST && pend_q |-> !active_q[pend_idx_q])
		else $error("expiring slot still active");

endmodule
